// ===== design/vcfe_pkg.sv =====
package vcfe_pkg;

	// input beat: one velocity command, Q4.12 m/s
	typedef struct packed {
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] vel_z;
	} cmd_t;

	// output beat: one frame byte
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} result_t;

	// scaled counts of one command, queued between front and back
	typedef struct packed {
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] cz;
	} counts_t;

	// configuration registers
	typedef struct packed {
		logic signed [15:0] min_x;
		logic signed [15:0] max_x;
		logic signed [15:0] min_y;
		logic signed [15:0] max_y;
		logic signed [15:0] min_z;
		logic signed [15:0] max_z;
		logic [23:0]        count_gain;
	} cfg_t;

	// front pipeline occupancy
	typedef struct packed {
		logic valid_s1;
		logic valid_s2;
	} front_stat_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_X      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Y      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Z      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Z      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_GAIN = 3'd6;

	localparam logic signed [15:0] RST_MIN  = -16'sd5734;
	localparam logic signed [15:0] RST_MAX  = 16'sd5734;
	localparam logic [23:0]        RST_GAIN = 24'd5991771;

	// Q4.12 * Q16.8 product has 20 fraction bits
	localparam int unsigned FRAC_BITS = 20;

	localparam logic [7:0] FRAME_HEAD = 8'h7B;
	localparam logic [7:0] FRAME_TAIL = 8'h7D;

	// byte positions in the frame
	localparam int unsigned   BIDX_W    = 4;
	localparam logic [3:0] BYTE_HEAD = 4'd0;
	localparam logic [3:0] BYTE_PAD0 = 4'd1;
	localparam logic [3:0] BYTE_PAD1 = 4'd2;
	localparam logic [3:0] BYTE_XH   = 4'd3;
	localparam logic [3:0] BYTE_XL   = 4'd4;
	localparam logic [3:0] BYTE_YH   = 4'd5;
	localparam logic [3:0] BYTE_YL   = 4'd6;
	localparam logic [3:0] BYTE_ZH   = 4'd7;
	localparam logic [3:0] BYTE_ZL   = 4'd8;
	localparam logic [3:0] BYTE_BCC  = 4'd9;
	localparam logic [3:0] BYTE_TAIL = 4'd10;

endpackage

// ===== design/vcfe_front.sv =====
module vcfe_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  vcfe_pkg::cmd_t         cmd,
	input  vcfe_pkg::cfg_t         cfg,
	output logic                   push,
	output vcfe_pkg::counts_t      push_data,
	output vcfe_pkg::front_stat_t  stat
);

	logic signed [15:0] vel [3];
	logic signed [15:0] lo  [3];
	logic signed [15:0] hi  [3];
	logic signed [15:0] clamped [3];
	logic [16:0]        mag [3];

	logic        valid_s1;
	logic [16:0] mag_s1 [3];
	logic [2:0]  neg_s1;

	logic        valid_s2;
	logic [15:0] cnt_s2 [3];
	logic [2:0]  neg_s2;

	logic [40:0] prod [3];
	logic [15:0] cnt_out [3];

	always_comb begin
		vel[0] = cmd.vel_x;
		vel[1] = cmd.vel_y;
		vel[2] = cmd.vel_z;
		lo[0]  = cfg.min_x;
		lo[1]  = cfg.min_y;
		lo[2]  = cfg.min_z;
		hi[0]  = cfg.max_x;
		hi[1]  = cfg.max_y;
		hi[2]  = cfg.max_z;
		for (int a = 0; a < 3; a++) begin
			// inverted limits: the minimum wins
			if (lo[a] > hi[a]) begin
				clamped[a] = lo[a];
			end else if (vel[a] < lo[a]) begin
				clamped[a] = lo[a];
			end else if (vel[a] > hi[a]) begin
				clamped[a] = hi[a];
			end else begin
				clamped[a] = vel[a];
			end
			if (clamped[a][15]) begin
				mag[a] = 17'(-{clamped[a][15], clamped[a]});
			end else begin
				mag[a] = {1'b0, clamped[a]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			mag_s1[a] <= mag[a];
			neg_s1[a] <= clamped[a][15];
		end
	end

	// magnitude times gain, truncated toward zero, low 16 bits kept
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			prod[a] = 41'(mag_s1[a]) * 41'(cfg.count_gain);
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			cnt_s2[a] <= prod[a][vcfe_pkg::FRAC_BITS +: 16];
		end
		neg_s2 <= neg_s1;
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			cnt_out[a] = neg_s2[a] ? 16'(-cnt_s2[a]) : cnt_s2[a];
		end
	end

	assign push         = valid_s2;
	assign push_data.cx = cnt_out[0];
	assign push_data.cy = cnt_out[1];
	assign push_data.cz = cnt_out[2];
	assign stat.valid_s1 = valid_s1;
	assign stat.valid_s2 = valid_s2;

`ifndef SYNTHESIS
	a_push_follows_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##2 push)
		else $error("front: accepted command did not reach the queue");
`endif

endmodule

// ===== design/vcfe_queue.sv =====
module vcfe_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  vcfe_pkg::counts_t             push_data,
	input  logic                          pop,
	output vcfe_pkg::counts_t             pop_data,
	output logic                          not_empty,
	output logic [$clog2(DEPTH+1)-1:0]    count
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH+1);

	vcfe_pkg::counts_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		if (p == PW'(DEPTH-1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_data  = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CW'(DEPTH)) || pop)
		else $error("queue: push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue: pop from empty queue");
`endif

endmodule

// ===== design/vcfe_back.sv =====
module vcfe_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 avail,
	input  vcfe_pkg::counts_t    frame_counts,
	output logic                 pop,
	output logic                 result_valid,
	output vcfe_pkg::result_t    result
);

	logic                       active_q;
	logic [vcfe_pkg::BIDX_W-1:0] idx_q;
	vcfe_pkg::counts_t          frame_q;
	logic [7:0]                 bcc_q;
	logic                       at_last;
	logic [7:0]                 byte_sel;
	logic [7:0]                 bcc_new;
	logic                       result_valid_q;
	vcfe_pkg::result_t          result_q;

	assign at_last = (idx_q == vcfe_pkg::BYTE_TAIL);
	assign pop     = avail && (!active_q || at_last);

	// the two zero pad bytes drop out of the checksum
	assign bcc_new = vcfe_pkg::FRAME_HEAD
		^ frame_counts.cx[15:8] ^ frame_counts.cx[7:0]
		^ frame_counts.cy[15:8] ^ frame_counts.cy[7:0]
		^ frame_counts.cz[15:8] ^ frame_counts.cz[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			idx_q    <= vcfe_pkg::BYTE_HEAD;
		end else if (active_q) begin
			idx_q <= idx_q + 1'b1;
			if (at_last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= frame_counts;
			bcc_q   <= bcc_new;
		end
	end

	always_comb begin
		unique case (idx_q)
			vcfe_pkg::BYTE_HEAD: byte_sel = vcfe_pkg::FRAME_HEAD;
			vcfe_pkg::BYTE_PAD0: byte_sel = 8'h00;
			vcfe_pkg::BYTE_PAD1: byte_sel = 8'h00;
			vcfe_pkg::BYTE_XH:   byte_sel = frame_q.cx[15:8];
			vcfe_pkg::BYTE_XL:   byte_sel = frame_q.cx[7:0];
			vcfe_pkg::BYTE_YH:   byte_sel = frame_q.cy[15:8];
			vcfe_pkg::BYTE_YL:   byte_sel = frame_q.cy[7:0];
			vcfe_pkg::BYTE_ZH:   byte_sel = frame_q.cz[15:8];
			vcfe_pkg::BYTE_ZL:   byte_sel = frame_q.cz[7:0];
			vcfe_pkg::BYTE_BCC:  byte_sel = bcc_q;
			vcfe_pkg::BYTE_TAIL: byte_sel = vcfe_pkg::FRAME_TAIL;
			default:             byte_sel = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		result_q.frame_byte <= byte_sel;
		result_q.last_byte  <= at_last;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_tail_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_byte) |-> (result.frame_byte == vcfe_pkg::FRAME_TAIL))
		else $error("back: last beat is not the closing byte");
	a_frame_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_byte) |-> $past(result_valid, 10))
		else $error("back: frame beats not back to back");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (idx_q <= vcfe_pkg::BYTE_TAIL))
		else $error("back: byte index past frame end");
`endif

endmodule

// ===== design/velocity_command_frame_encoder.sv =====
// Channel  Direction  Beat                          Accepted when
// cmd      in         vel_x, vel_y, vel_z (Q4.12)   start && !busy at clk rise
// result   out        frame_byte, last_byte         result_valid at clk rise
// cfg      in         cfg_index, cfg_data           cfg_we at clk rise
//
// A command produces 11 result beats on consecutive cycles; the first beat
// follows the front stages, queue, serializer and output register when the
// back end is free. The serializer pops a new command only at a frame end.
// Up to QUEUE_DEPTH commands may be in flight in front of the serializer;
// busy rises when the front pipeline plus queue would hold more.
// Reset (arst_n low) empties the pipeline and queue, loads the limit and
// gain registers with their defaults. The receiver cannot stall results.
module velocity_command_frame_encoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// command channel
	input  logic                                    start,
	output logic                                    busy,
	input  vcfe_pkg::cmd_t                          cmd,
	// result channel
	output logic                                    result_valid,
	output vcfe_pkg::result_t                       result,
	// configuration write port
	input  logic                                    cfg_we,
	input  logic [vcfe_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [vcfe_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);
	localparam int unsigned OW = $clog2(QUEUE_DEPTH+3);

	vcfe_pkg::cfg_t        cfg_q;
	vcfe_pkg::front_stat_t front_stat;
	vcfe_pkg::counts_t     push_data;
	vcfe_pkg::counts_t     pop_data;
	logic                  push;
	logic                  pop;
	logic                  q_not_empty;
	logic [CW-1:0]         q_count;
	logic [OW-1:0]         occupancy;
	logic                  take;

	// Config registers. Limits take the low 16 bits, gain all 24.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_x      <= vcfe_pkg::RST_MIN;
			cfg_q.max_x      <= vcfe_pkg::RST_MAX;
			cfg_q.min_y      <= vcfe_pkg::RST_MIN;
			cfg_q.max_y      <= vcfe_pkg::RST_MAX;
			cfg_q.min_z      <= vcfe_pkg::RST_MIN;
			cfg_q.max_z      <= vcfe_pkg::RST_MAX;
			cfg_q.count_gain <= vcfe_pkg::RST_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vcfe_pkg::REG_MIN_X:      cfg_q.min_x      <= cfg_data[15:0];
				vcfe_pkg::REG_MAX_X:      cfg_q.max_x      <= cfg_data[15:0];
				vcfe_pkg::REG_MIN_Y:      cfg_q.min_y      <= cfg_data[15:0];
				vcfe_pkg::REG_MAX_Y:      cfg_q.max_y      <= cfg_data[15:0];
				vcfe_pkg::REG_MIN_Z:      cfg_q.min_z      <= cfg_data[15:0];
				vcfe_pkg::REG_MAX_Z:      cfg_q.max_z      <= cfg_data[15:0];
				vcfe_pkg::REG_COUNT_GAIN: cfg_q.count_gain <= cfg_data;
				default: ; // unused index: write dropped
			endcase
		end
	end

	// Credit check: everything past the input that has not yet been popped
	// must fit into the queue, so the front never has to stall.
	assign occupancy = OW'(q_count) + OW'(front_stat.valid_s1) + OW'(front_stat.valid_s2);
	assign busy      = (occupancy >= OW'(QUEUE_DEPTH));
	assign take      = start && !busy;

	// front: clamp, abs, scale
	vcfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.push      (push),
		.push_data (push_data),
		.stat      (front_stat)
	);

	// decoupling queue of scaled commands
	vcfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	// back: frame assembly and byte serializer
	vcfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.avail        (q_not_empty),
		.frame_counts (pop_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

`ifndef SYNTHESIS
	a_idle_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count == '0 && !front_stat.valid_s1 && !front_stat.valid_s2) |-> !busy)
		else $error("top: busy with nothing in flight");
	a_busy_blocks_take: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !take)
		else $error("top: command taken while busy");
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= OW'(QUEUE_DEPTH))
		else $error("top: in-flight commands exceed queue depth");
`endif

endmodule

// ===== sim/velocity_command_frame_encoder_checker.sv =====
`timescale 1ns / 1ps

// Watches the command, config and result channels, predicts each 11-byte
// frame from its own copy of the registers and compares beat by beat.
module velocity_command_frame_encoder_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  vcfe_pkg::cmd_t                  cmd,
	input  logic                            result_valid,
	input  vcfe_pkg::result_t               result,
	input  logic                            cfg_we,
	input  logic [vcfe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vcfe_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              pending
);

	vcfe_pkg::cfg_t    regs;
	vcfe_pkg::result_t frame_bytes_q[$];
	int                errs;

	// clamp (min wins when min > max), scale by Q16.8 gain, keep low 16 bits
	function automatic logic [15:0] scaled_axis(logic signed [15:0] v,
		logic signed [15:0] lo, logic signed [15:0] hi, logic [23:0] gain);
		logic signed [15:0] c;
		logic [16:0]        mag;
		logic [40:0]        prod;
		c = v;
		if (c < lo) c = lo;
		if (c > hi) c = hi;
		if (c < lo) c = lo;
		else if (c > hi) c = hi;
		mag  = c[15] ? (17'd0 - {c[15], c}) : {1'b0, c};
		prod = 41'(mag) * 41'(gain);
		return c[15] ? (16'd0 - prod[35:20]) : prod[35:20];
	endfunction

	task automatic push_frame(vcfe_pkg::cmd_t c);
		logic [15:0] cx, cy, cz;
		logic [7:0]  b[11];
		logic [7:0]  bcc;
		cx = scaled_axis(c.vel_x, regs.min_x, regs.max_x, regs.count_gain);
		cy = scaled_axis(c.vel_y, regs.min_y, regs.max_y, regs.count_gain);
		cz = scaled_axis(c.vel_z, regs.min_z, regs.max_z, regs.count_gain);
		b[vcfe_pkg::BYTE_HEAD] = vcfe_pkg::FRAME_HEAD;
		b[vcfe_pkg::BYTE_PAD0] = 8'h00;
		b[vcfe_pkg::BYTE_PAD1] = 8'h00;
		b[vcfe_pkg::BYTE_XH]   = cx[15:8];
		b[vcfe_pkg::BYTE_XL]   = cx[7:0];
		b[vcfe_pkg::BYTE_YH]   = cy[15:8];
		b[vcfe_pkg::BYTE_YL]   = cy[7:0];
		b[vcfe_pkg::BYTE_ZH]   = cz[15:8];
		b[vcfe_pkg::BYTE_ZL]   = cz[7:0];
		bcc = 8'h00;
		for (int i = 0; i < vcfe_pkg::BYTE_BCC; i++) bcc ^= b[i];
		b[vcfe_pkg::BYTE_BCC]  = bcc;
		b[vcfe_pkg::BYTE_TAIL] = vcfe_pkg::FRAME_TAIL;
		for (int i = 0; i <= vcfe_pkg::BYTE_TAIL; i++)
			frame_bytes_q.push_back('{frame_byte: b[i],
				last_byte: (i == vcfe_pkg::BYTE_TAIL)});
	endtask

	always @(posedge clk or negedge arst_n) begin
		vcfe_pkg::result_t want;
		if (!arst_n) begin
			frame_bytes_q.delete();
			errs       = 0;
			regs       <= '{min_x: vcfe_pkg::RST_MIN, max_x: vcfe_pkg::RST_MAX,
			                min_y: vcfe_pkg::RST_MIN, max_y: vcfe_pkg::RST_MAX,
			                min_z: vcfe_pkg::RST_MIN, max_z: vcfe_pkg::RST_MAX,
			                count_gain: vcfe_pkg::RST_GAIN};
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (result_valid) begin
				if (frame_bytes_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: unexpected beat byte=%02h last=%0b",
							$realtime, result.frame_byte, result.last_byte);
				end else begin
					want = frame_bytes_q.pop_front();
					if (result.frame_byte !== want.frame_byte ||
					    result.last_byte !== want.last_byte) begin
						errs++;
						if (errs <= 10)
							$display("%0t: mismatch byte exp=%02h got=%02h last exp=%0b got=%0b",
								$realtime, want.frame_byte, result.frame_byte,
								want.last_byte, result.last_byte);
					end
				end
			end
			if (start && !busy) push_frame(cmd);
			if (cfg_we) begin
				case (cfg_index)
					vcfe_pkg::REG_MIN_X:      regs.min_x      <= $signed(cfg_data[15:0]);
					vcfe_pkg::REG_MAX_X:      regs.max_x      <= $signed(cfg_data[15:0]);
					vcfe_pkg::REG_MIN_Y:      regs.min_y      <= $signed(cfg_data[15:0]);
					vcfe_pkg::REG_MAX_Y:      regs.max_y      <= $signed(cfg_data[15:0]);
					vcfe_pkg::REG_MIN_Z:      regs.min_z      <= $signed(cfg_data[15:0]);
					vcfe_pkg::REG_MAX_Z:      regs.max_z      <= $signed(cfg_data[15:0]);
					vcfe_pkg::REG_COUNT_GAIN: regs.count_gain <= cfg_data;
					default: ;
				endcase
			end
			fail_count <= errs;
			pending    <= frame_bytes_q.size();
		end
	end

endmodule

// ===== sim/velocity_command_frame_encoder_test.sv =====
`timescale 1ns / 1ps

module velocity_command_frame_encoder_test;

	// index past the last register; writes to it must be dropped
	localparam logic [vcfe_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	// cycles to sit after the last expected beat, covers the pipeline latency
	localparam int DRAIN_CYCLES = 20;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            start = 1'b0;
	logic                            busy;
	vcfe_pkg::cmd_t                  cmd = '0;
	logic                            result_valid;
	vcfe_pkg::result_t               result;
	logic                            cfg_we = 1'b0;
	logic [vcfe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [vcfe_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	int                              fail_count;
	int                              pending;

	// limits last written, only used to aim stimulus at the clamp edges
	logic signed [15:0] lim_lo[3];
	logic signed [15:0] lim_hi[3];
	bit                 idle_on;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	velocity_command_frame_encoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	velocity_command_frame_encoder_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// hold start high until the beat is taken; start is left high so a
	// back-to-back beat needs no second assignment in the same step
	task automatic send_cmd(logic signed [15:0] x, logic signed [15:0] y,
		logic signed [15:0] z);
		start <= 1'b1;
		cmd   <= '{vel_x: x, vel_y: y, vel_z: z};
		do @(posedge clk); while (busy);
	endtask

	// stop sending and wait for every predicted byte to come out
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(logic [vcfe_pkg::CFG_IDX_W-1:0] idx,
		logic [vcfe_pkg::CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
	endtask

	// all seven registers from the shadow limits; junk in the unused top byte
	task automatic write_all(logic [23:0] gain);
		write_reg(vcfe_pkg::REG_MIN_X, {8'($urandom), lim_lo[0]});
		write_reg(vcfe_pkg::REG_MAX_X, {8'($urandom), lim_hi[0]});
		write_reg(vcfe_pkg::REG_MIN_Y, {8'($urandom), lim_lo[1]});
		write_reg(vcfe_pkg::REG_MAX_Y, {8'($urandom), lim_hi[1]});
		write_reg(vcfe_pkg::REG_MIN_Z, {8'($urandom), lim_lo[2]});
		write_reg(vcfe_pkg::REG_MAX_Z, {8'($urandom), lim_hi[2]});
		write_reg(vcfe_pkg::REG_COUNT_GAIN, gain);
		cfg_we <= 1'b0;
	endtask

	task automatic random_config();
		logic [23:0] gain;
		for (int a = 0; a < 3; a++) begin
			if ($urandom_range(0, 5) == 0) begin
				// inverted window: minimum should win
				lim_lo[a] = 16'($urandom_range(1, 32767));
				lim_hi[a] = 16'(-int'($urandom_range(0, 32768)));
			end else begin
				lim_lo[a] = 16'(-int'($urandom_range(0, 32768)));
				lim_hi[a] = 16'($urandom_range(0, 32767));
			end
		end
		case ($urandom_range(0, 3))
			0: gain = 24'($urandom);
			1: gain = 24'($urandom_range(0, 4096));
			2: gain = 24'hFF_FFFF;
			default: gain = vcfe_pkg::RST_GAIN;
		endcase
		write_all(gain);
	endtask

	function automatic logic signed [15:0] pick_vel(int a);
		logic signed [15:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = 16'($urandom);
			2: v = lim_lo[a] + 16'($urandom_range(0, 4)) - 16'sd2;
			3: v = lim_hi[a] + 16'($urandom_range(0, 4)) - 16'sd2;
			4: begin
				case ($urandom_range(0, 3))
					0: v = 16'sh8000;
					1: v = 16'sh7FFF;
					2: v = 16'sd0;
					default: v = -16'sd1;
				endcase
			end
			default: v = 16'($urandom_range(0, 4095)) - 16'sd2048;
		endcase
		return v;
	endfunction

	task automatic random_commands(int n);
		for (int i = 0; i < n; i++) begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			send_cmd(pick_vel(0), pick_vel(1), pick_vel(2));
		end
	endtask

	initial begin
		#2_000_000;
		$display("velocity_command_frame_encoder verification failed");
		$finish;
	end

	initial begin
		for (int a = 0; a < 3; a++) begin
			lim_lo[a] = vcfe_pkg::RST_MIN;
			lim_hi[a] = vcfe_pkg::RST_MAX;
		end
		idle_on = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits: inside, on and just past each edge, full-scale inputs
		send_cmd(16'sd0, 16'sd0, 16'sd0);
		send_cmd(16'sh7FFF, 16'sh8000, 16'sd1);
		send_cmd(vcfe_pkg::RST_MAX, vcfe_pkg::RST_MIN, -16'sd1);
		send_cmd(vcfe_pkg::RST_MAX + 16'sd1, vcfe_pkg::RST_MIN - 16'sd1, 16'sd4096);
		send_cmd(16'sh5555, -16'sh5556, 16'sh2AAA);
		send_cmd(-16'sd4096, 16'sd2867, -16'sd2867);
		drain();

		// widest window, largest gain: counts wrap past 16 bits
		for (int a = 0; a < 3; a++) begin
			lim_lo[a] = 16'sh8000;
			lim_hi[a] = 16'sh7FFF;
		end
		write_all(24'hFF_FFFF);
		send_cmd(16'sh7FFF, 16'sh8000, -16'sd1);
		send_cmd(16'sd1, 16'sh4000, -16'sh4000);
		send_cmd(16'shAAAA, 16'sh5555, 16'sh00FF);
		drain();

		// inverted x and z windows with unity gain; x collapses to its minimum
		lim_lo[0] = 16'sd1000;  lim_hi[0] = -16'sd1000;
		lim_lo[1] = 16'sd0;     lim_hi[1] = 16'sd0;
		lim_lo[2] = 16'sh7FFF;  lim_hi[2] = 16'sh8000;
		write_all(24'd256);
		@(posedge clk);
		// write to a nonexistent register must leave the gain alone
		write_reg(REG_UNUSED, 24'hFF_FFFF);
		cfg_we <= 1'b0;
		send_cmd(16'sd0, 16'sd5, -16'sd5);
		send_cmd(16'sh8000, 16'sh7FFF, 16'sd0);
		send_cmd(16'sh7FFF, 16'sh8000, 16'sd1234);
		drain();

		// zero gain: every count is zero
		write_reg(vcfe_pkg::REG_COUNT_GAIN, 24'd0);
		cfg_we <= 1'b0;
		send_cmd(16'sh7FFF, 16'sh8000, 16'sd300);
		drain();

		// random part, a new register setting per phase; the drain between
		// phases also holds the sender off until the output is empty
		idle_on = 1'b1;
		repeat (4) begin
			random_config();
			random_commands(48);
			drain();
		end

		// closing stretch at full rate
		idle_on = 1'b0;
		random_config();
		random_commands(50);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("velocity_command_frame_encoder verification clean");
		end else begin
			$display("velocity_command_frame_encoder verification failed");
		end
		$finish;
	end

endmodule
